// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, skipped while reset is held
`define FBSD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// clocked property that must never hold
`define FBSD_NEVER(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");

`endif

// ===== rtl/fbsd_pkg.sv =====
// shared types, constants and decode functions for the block-scaled dot unit
`timescale 1ns / 1ps
`default_nettype none

package fbsd_pkg;

    localparam int LANES_DEF    = 8;
    localparam int ACC_BITS_DEF = 60;

    localparam int WORD_LANES = 8;    // codes carried in one 32-bit word
    localparam int CODE_W     = 4;
    localparam int HALF_W     = 4;    // half count 0..12
    localparam int LMAG_W     = 8;    // up to 144
    localparam int LPROD_W    = 9;    // signed lane product
    localparam int LSUM_W     = 12;   // signed sum of up to eight lanes
    localparam int SCALE_W    = 18;   // scale units, up to 15 << 14
    localparam int SPROD_W    = 36;
    localparam int ITEM_W     = 50;   // signed per-item sum in 22-fraction units
    localparam int WORD_W     = 32;
    localparam int SBYTE_W    = 8;
    localparam int S_TDATA_W  = 2 * WORD_W + 2 * SBYTE_W;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    // e2m1 magnitude as a count of halves
    function automatic logic [HALF_W-1:0] half_count(input logic [2:0] code);
        logic [HALF_W-1:0] h;
        case (code)
            3'd0:    h = 4'd0;
            3'd1:    h = 4'd1;
            3'd2:    h = 4'd2;
            3'd3:    h = 4'd3;
            3'd4:    h = 4'd4;
            3'd5:    h = 4'd6;
            3'd6:    h = 4'd8;
            3'd7:    h = 4'd12;
            default: h = 4'd0;
        endcase
        return h;
    endfunction

    // ue4m3 byte as a multiple of 2^-9, bit 7 ignored
    function automatic logic [SCALE_W-1:0] scale_units(input logic [SBYTE_W-1:0] b);
        logic [3:0]         e;
        logic [2:0]         m;
        logic [SCALE_W-1:0] s;
        e = b[6:3];
        m = b[2:0];
        if (e == 4'd0) begin
            s = SCALE_W'(m);
        end else begin
            s = SCALE_W'({1'b1, m}) << (e - 4'd1);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fp4_block_scaled_dot_top.sv =====
// top level of the block-scaled four-bit dot-product accumulator
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// block-scaled e2m1 dot product: each item brings eight 4-bit codes per operand
// and one ue4m3 scale byte per operand; LANES lanes decode and multiply the code
// pairs side by side, a merge stage adds the lane products and multiplies by the
// product of the two scales, and a saturating accumulator keeps an exact signed
// sum with 22 fraction bits. the item marked tlast emits the sum (tdata, zero
// filled to whole bytes) with the sticky overflow flag (tuser) and clears both.
// the pipeline takes one item per cycle while it is not stalled: the accumulate stage
// closes its wide add and clamp combinationally, so the running sum never holds the
// input back. an accepted item passes the lane, lane-sum and scale-multiply registers
// and then lands in the accumulator; for a last item the result register loads
// together with the accumulator. the whole pipeline holds while a result waits and
// the downstream side stalls.
module fp4_block_scaled_dot_top
    import fbsd_pkg::*;
#(
    parameter int LANES    = LANES_DEF,
    parameter int ACC_BITS = ACC_BITS_DEF,
    localparam int OUT_W   = ((ACC_BITS + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input items
    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    // a_word [31:0], b_word [63:32], a_scale [71:64], b_scale [79:72]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                 s_axis_tlast,
    // results
    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // dot_sum [ACC_BITS-1:0], zero filled above
    output      logic [OUT_W-1:0]     m_axis_tdata,
    // saturated [0]
    output      logic                 m_axis_tuser
);

    logic                       w_en;
    t_ctl                       r_ctl1;
    t_ctl                       w_ctl3;
    logic [WORD_W-1:0]          w_a_word;
    logic [WORD_W-1:0]          w_b_word;
    logic [SBYTE_W-1:0]         w_a_scale;
    logic [SBYTE_W-1:0]         w_b_scale;
    logic signed [LPROD_W-1:0]  w_prods [LANES];
    logic [SPROD_W-1:0]         w_sprod;
    logic signed [ITEM_W-1:0]   w_item;
    logic [ACC_BITS-1:0]        w_sum;

    // payload unpacking
    assign w_a_word  = s_axis_tdata[WORD_W-1:0];
    assign w_b_word  = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign w_a_scale = s_axis_tdata[2*WORD_W+SBYTE_W-1:2*WORD_W];
    assign w_b_scale = s_axis_tdata[S_TDATA_W-1:2*WORD_W+SBYTE_W];

    // pipeline moves unless a finished result is held by the downstream side
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (w_en) begin
            r_ctl1.valid <= s_axis_tvalid;
            r_ctl1.last  <= s_axis_tlast;
        end
    end

    // lanes past the 32-bit word see code zero and add nothing
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        if (g < WORD_LANES) begin : g_live
            fbsd_lane u_lane (
                .i_clk    (i_clk),
                .i_en     (w_en),
                .i_code_a (w_a_word[CODE_W*g +: CODE_W]),
                .i_code_b (w_b_word[CODE_W*g +: CODE_W]),
                .o_prod   (w_prods[g])
            );
        end else begin : g_idle
            fbsd_lane u_lane (
                .i_clk    (i_clk),
                .i_en     (w_en),
                .i_code_a ({CODE_W{1'b0}}),
                .i_code_b ({CODE_W{1'b0}}),
                .o_prod   (w_prods[g])
            );
        end
    end

    fbsd_scale u_scale (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_a_scale (w_a_scale),
        .i_b_scale (w_b_scale),
        .o_sprod   (w_sprod)
    );

    fbsd_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (r_ctl1),
        .i_prods (w_prods),
        .i_sprod (w_sprod),
        .o_ctl   (w_ctl3),
        .o_item  (w_item)
    );

    fbsd_acc #(
        .ACC_BITS (ACC_BITS)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl3),
        .i_item  (w_item),
        .o_valid (m_axis_tvalid),
        .o_sum   (w_sum),
        .o_sat   (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'(w_sum);

    // a held result must freeze the input side
    `FBSD_NEVER(a_stall_blocks_input, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready && s_axis_tready)
    // an accepted item lands in the lane stage
    `FBSD_ASSERT(a_accept_fills_lanes, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> r_ctl1.valid)
    // a new result only follows a last item in the accumulate stage
    `FBSD_ASSERT(a_result_from_last, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(w_ctl3.valid && w_ctl3.last))

endmodule

`default_nettype wire

// ===== rtl/fbsd_lane.sv =====
// one lane: decodes an a/b code pair and registers the signed product
`timescale 1ns / 1ps
`default_nettype none

module fbsd_lane
    import fbsd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [CODE_W-1:0]         i_code_a,
    input  wire logic [CODE_W-1:0]         i_code_b,
    output      logic signed [LPROD_W-1:0] o_prod
);

    logic [LMAG_W-1:0]         w_mag;
    logic signed [LPROD_W-1:0] n_prod;
    logic signed [LPROD_W-1:0] r_prod;

    always_comb begin
        w_mag = LMAG_W'(half_count(i_code_a[2:0])) * LMAG_W'(half_count(i_code_b[2:0]));
        // signs differ -> negative; minus zero gives zero magnitude anyway
        if (i_code_a[3] ^ i_code_b[3]) begin
            n_prod = -$signed(LPROD_W'(w_mag));
        end else begin
            n_prod = $signed(LPROD_W'(w_mag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/fbsd_scale.sv =====
// decodes both scale bytes and registers their product
`timescale 1ns / 1ps
`default_nettype none

module fbsd_scale
    import fbsd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [SBYTE_W-1:0] i_a_scale,
    input  wire logic [SBYTE_W-1:0] i_b_scale,
    output      logic [SPROD_W-1:0] o_sprod
);

    logic [SPROD_W-1:0] r_sprod;
    logic [SPROD_W-1:0] n_sprod;

    assign n_sprod = SPROD_W'(scale_units(i_a_scale)) * SPROD_W'(scale_units(i_b_scale));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sprod <= n_sprod;
        end
    end

    assign o_sprod = r_sprod;

endmodule

`default_nettype wire

// ===== rtl/fbsd_merge.sv =====
// merge stage: sums the lane products, then applies the combined scale
`timescale 1ns / 1ps
`default_nettype none

module fbsd_merge
    import fbsd_pkg::*;
#(
    parameter int LANES = LANES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire t_ctl                      i_ctl,
    input  wire logic signed [LPROD_W-1:0] i_prods [LANES],
    input  wire logic [SPROD_W-1:0]        i_sprod,
    output      t_ctl                      o_ctl,
    output      logic signed [ITEM_W-1:0]  o_item
);

    localparam int MUL_W = LSUM_W + SPROD_W + 1;

    logic signed [LSUM_W-1:0] w_lsum;
    logic signed [LSUM_W-1:0] r_lsum;
    logic [SPROD_W-1:0]       r_sprod;
    t_ctl                     r_ctl2;
    t_ctl                     r_ctl3;
    logic signed [MUL_W-1:0]  w_mul;
    logic signed [ITEM_W-1:0] r_item;

    // lanes past the word carry zero, so the narrow sum cannot overflow
    always_comb begin
        w_lsum = '0;
        for (int i = 0; i < LANES; i++) begin
            w_lsum = w_lsum + LSUM_W'(i_prods[i]);
        end
    end

    assign w_mul = MUL_W'(r_lsum) * $signed({1'b0, r_sprod});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lsum  <= w_lsum;
            r_sprod <= i_sprod;
            // times four brings 2^-20 units to 22 fraction bits
            r_item  <= ITEM_W'(w_mul) <<< 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl2 <= i_ctl;
            r_ctl3 <= r_ctl2;
        end
    end

    assign o_ctl  = r_ctl3;
    assign o_item = r_item;

endmodule

`default_nettype wire

// ===== rtl/fbsd_acc.sv =====
// saturating running sum with sticky overflow flag and result register
`timescale 1ns / 1ps
`default_nettype none

module fbsd_acc
    import fbsd_pkg::*;
#(
    parameter int ACC_BITS = ACC_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire t_ctl                     i_ctl,
    input  wire logic signed [ITEM_W-1:0] i_item,
    output      logic                     o_valid,
    output      logic [ACC_BITS-1:0]      o_sum,
    output      logic                     o_sat
);

    localparam int W = ((ACC_BITS > ITEM_W) ? ACC_BITS : ITEM_W) + 1;

    logic signed [ACC_BITS-1:0] r_sum;
    logic                       r_ovf;
    logic                       r_out_valid;
    logic signed [ACC_BITS-1:0] r_out_sum;
    logic                       r_out_sat;

    logic signed [W-1:0]        w_full;
    logic signed [W-1:0]        w_hi;
    logic signed [W-1:0]        w_lo;
    logic                       w_over;
    logic                       w_under;
    logic signed [ACC_BITS-1:0] n_sum;
    logic                       n_ovf;

    always_comb begin
        w_hi = '0;
        w_hi[ACC_BITS-2:0] = '1;
        w_lo = '1;
        w_lo[ACC_BITS-2:0] = '0;
        w_full  = W'(r_sum) + W'(i_item);
        w_over  = w_full > w_hi;
        w_under = w_full < w_lo;
        if (w_over) begin
            n_sum = ACC_BITS'(w_hi);
        end else if (w_under) begin
            n_sum = ACC_BITS'(w_lo);
        end else begin
            n_sum = ACC_BITS'(w_full);
        end
        n_ovf = r_ovf | w_over | w_under;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= i_ctl.valid & i_ctl.last;
            if (i_ctl.valid) begin
                if (i_ctl.last) begin
                    r_sum <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_sum <= n_sum;
                    r_ovf <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_ctl.valid && i_ctl.last) begin
            r_out_sum <= n_sum;
            r_out_sat <= n_ovf;
        end
    end

    assign o_valid = r_out_valid;
    assign o_sum   = r_out_sum;
    assign o_sat   = r_out_sat;

endmodule

`default_nettype wire
